// ===== sv/urx_pkg.sv =====
// Shared types for the receive byte ring: request codes, result codes, control bundles.
`timescale 1ns / 1ps
package urx_pkg;

    typedef enum logic [1:0] {
        REQ_BYTE     = 2'd0,
        REQ_LINE_ERR = 2'd1,
        REQ_READ     = 2'd2,
        REQ_FLUSH    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_DROPPED   = 3'd1,
        ST_ERR_CNT   = 3'd2,
        ST_READ_BYTE = 3'd3,
        ST_READ_EMPTY = 3'd4,
        ST_BAD_LEN   = 3'd5,
        ST_FLUSHED   = 3'd6
    } t_status;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic bad_len;
        logic empty;
        logic out_free;
        logic last_byte;
    } t_stat;

endpackage

// ===== sv/urx_ctrl.sv =====
// Sequencer for the receive byte ring: takes one item, runs it, drains reads byte by byte.
`timescale 1ns / 1ps
module urx_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  urx_pkg::t_stat i_stat,
    output urx_pkg::t_cmd  o_cmd
);
    import urx_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   read_run;

    assign read_run   = (i_stat.req == REQ_READ) && !i_stat.bad_len && !i_stat.empty;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (read_run) begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_EMIT;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.last_byte ? S_IDLE : S_FETCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/urx_dpath.sv =====
// Datapath of the receive byte ring: storage, indexes, drop counter and result register.
`timescale 1ns / 1ps
module urx_dpath #(
    parameter int RING_DEPTH = 256,
    parameter int MAX_READ   = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  urx_pkg::t_cmd     i_cmd,
    output urx_pkg::t_stat    o_stat,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_read_max,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [7:0]        o_data_byte,
    output logic              o_last,
    output logic [7:0]        o_fill_count,
    output logic [31:0]       o_drop_count
);
    import urx_pkg::*;

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int FWX = (AW > 8) ? AW : 8;

    logic [7:0]    r_mem [RING_DEPTH];
    logic [7:0]    r_rdata;
    t_req          r_req;
    logic [7:0]    r_byte;
    logic [7:0]    r_rem;
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [31:0]   r_lost;
    logic          r_out_valid;
    t_status       r_status;
    logic [7:0]    r_data;
    logic          r_last;
    logic [7:0]    r_fill;

    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [31:0]   n_lost;
    logic [7:0]    n_rem;
    t_status       n_status;
    logic [7:0]    n_data;
    logic          n_last;
    logic [7:0]    n_fill;
    logic          full;
    logic          empty;
    logic          bad_len;
    logic          out_free;
    logic          last_byte;
    logic          mem_we;
    logic [AW-1:0] held;
    logic [FWX-1:0] held_x;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
        return (idx == AW'(RING_DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    assign full      = (idx_inc(r_wr) == r_rd);
    assign empty     = (r_rd == r_wr);
    assign bad_len   = (r_rem == 8'd0) || ({1'b0, r_rem} > 9'(MAX_READ));
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_byte = (r_rem == 8'd1) || (idx_inc(r_rd) == r_wr);
    assign mem_we    = i_cmd.exec && (r_req == REQ_BYTE) && !full;

    assign o_stat = '{req: r_req, bad_len: bad_len, empty: empty,
                      out_free: out_free, last_byte: last_byte};

    always_comb begin
        n_wr     = r_wr;
        n_rd     = r_rd;
        n_lost   = r_lost;
        n_rem    = r_rem;
        n_status = ST_STORED;
        n_data   = 8'd0;
        n_last   = 1'b1;
        if (i_cmd.exec) begin
            case (r_req)
                REQ_BYTE: begin
                    if (full) begin
                        n_lost   = r_lost + 32'd1;
                        n_status = ST_DROPPED;
                    end else begin
                        n_wr     = idx_inc(r_wr);
                        n_status = ST_STORED;
                    end
                end
                REQ_LINE_ERR: begin
                    n_lost   = r_lost + 32'd1;
                    n_status = ST_ERR_CNT;
                end
                REQ_FLUSH: begin
                    n_wr     = '0;
                    n_rd     = '0;
                    n_lost   = 32'd0;
                    n_status = ST_FLUSHED;
                end
                default: begin
                    n_status = bad_len ? ST_BAD_LEN : ST_READ_EMPTY;
                end
            endcase
        end else if (i_cmd.emit) begin
            n_rd     = idx_inc(r_rd);
            n_rem    = r_rem - 8'd1;
            n_status = ST_READ_BYTE;
            n_data   = r_rdata;
            n_last   = last_byte;
        end
    end

    always_comb begin
        held   = (n_wr >= n_rd) ? (n_wr - n_rd) : (n_wr + AW'(RING_DEPTH) - n_rd);
        held_x = FWX'(held);
        n_fill = (held_x > FWX'(255)) ? 8'hFF : held_x[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr] <= r_byte;
        end
        if (i_cmd.fetch) begin
            r_rdata <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= t_req'(i_req_type);
            r_byte <= i_rx_byte;
            r_rem  <= i_read_max;
        end else begin
            r_rem  <= n_rem;
        end
        if (i_cmd.exec || i_cmd.emit) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_last   <= n_last;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_lost      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_lost <= n_lost;
            if (i_cmd.exec || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_data_byte  = r_data;
    assign o_last       = r_last;
    assign o_fill_count = r_fill;
    assign o_drop_count = r_lost;

`ifndef ASSERT_OFF
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.exec && i_cmd.emit))
        else $error("single result and read byte loaded together");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec || i_cmd.emit) |-> out_free)
        else $error("result loaded over an untaken item");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !empty)
        else $error("byte drained from empty ring");
    a_lost_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_lost != $past(r_lost))) |->
        ((r_lost == $past(r_lost) + 32'd1) || (r_lost == 32'd0)))
        else $error("drop counter moved by other than one step or clear");
`endif

endmodule

// ===== sv/uart_rx_ring_drop_newest.sv =====
// Top level of the receive byte ring with drop-newest overflow and drop counter.
`timescale 1ns / 1ps
// Receive byte ring holding up to RING_DEPTH-1 bytes; a byte that arrives on a
// full ring is discarded and counted, as is a line-error item, and a flush item
// empties the ring and clears the 32-bit counter. One item is worked at a time:
// a store, drop, error, flush, bad-length or empty read loads one result, and a
// read that drains N bytes loads N results, since each byte takes a registered
// ring read and then a load of the result register. Every result load waits
// while the previous result is untaken. A new item is taken once the previous
// one has loaded its last result, even if that result still waits downstream.
// Reads longer than MAX_READ, or of zero length, return a single bad-length result.
module uart_rx_ring_drop_newest #(
    parameter int RING_DEPTH = 256,
    parameter int MAX_READ   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_read_max,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_data_byte,
    output logic        o_last,
    output logic [7:0]  o_fill_count,
    output logic [31:0] o_drop_count
);
    import urx_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    urx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    urx_dpath #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_rx_byte    (i_rx_byte),
        .i_read_max   (i_read_max),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_data_byte  (o_data_byte),
        .o_last       (o_last),
        .o_fill_count (o_fill_count),
        .o_drop_count (o_drop_count)
    );

endmodule
